// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== design/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Types, codes and controller/datapath interface for sorted_key_table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ACT_W        = 3;
  localparam int KEY_W        = 31;
  localparam int QTY_W        = 32;
  localparam int ST_W         = 3;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd1;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DUMP   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_EXISTS    = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [KEY_W-1:0]        part_key;
    logic signed [QTY_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [KEY_W-1:0]        found_key;
    logic signed [QTY_W-1:0] quantity;
    logic                    last;
  } res_t;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_COUNT, IDX_POS
  } idx_op_t;

  typedef enum logic [1:0] {RD_IDX, RD_IDX_M1, RD_IDX_P1} rd_sel_t;

  typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_NEW, WR_SUM} wr_sel_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;

  typedef enum logic [3:0] {
    RES_NONE, RES_FULL, RES_EXISTS, RES_NOT_FOUND, RES_HIT,
    RES_SUM, RES_NEW, RES_EMPTY, RES_DUMP
  } res_sel_t;

  typedef struct packed {
    logic     load_req;
    logic     cap_pos;
    idx_op_t  idx_op;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             full;
    logic             empty;
    logic             idx_eq_count;
    logic             idx_eq_pos;
    logic             idx_p1_eq_count;
    logic             key_ge;
    logic             hit;
  } sts_t;

endpackage

// ===== design/skt_ram.sv =====
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/skt_datapath.sv =====
// ----------------------------------------------------------------------------
// skt_datapath
// Request register, walk index, entry RAM, saturating adder and result regs.
// ----------------------------------------------------------------------------
module skt_datapath #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  skt_pkg::req_t req,
  input  skt_pkg::cmd_t cmd,
  output skt_pkg::sts_t sts,
  output logic          done,
  output skt_pkg::res_t res
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DW = skt_pkg::KEY_W + skt_pkg::QTY_W;
  localparam int QW = skt_pkg::QTY_W;

  skt_pkg::req_t         req_q;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         pos;
  logic [IW-1:0]         count;
  logic                  hit;
  logic signed [QW-1:0]  qty_hold;

  logic [IW-1:0]         idx_m1;
  logic [IW-1:0]         idx_p1;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DW-1:0]         wr_data;
  logic [DW-1:0]         rd_data;
  logic [skt_pkg::KEY_W-1:0] rd_key;
  logic signed [QW-1:0]  rd_qty;
  logic signed [QW:0]    sum;
  logic signed [QW-1:0]  sat;

  assign idx_m1 = idx - IW'(1);
  assign idx_p1 = idx + IW'(1);
  assign rd_key = rd_data[DW-1:QW];
  assign rd_qty = rd_data[QW-1:0];

  assign sum = {qty_hold[QW-1], qty_hold} + {req_q.amount[QW-1], req_q.amount};
  always_comb begin
    if (sum[QW] != sum[QW-1]) begin
      sat = sum[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      sat = sum[QW-1:0];
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      skt_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      skt_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
      default:            rd_addr = idx[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      skt_pkg::WR_SHIFT: begin
        wr_addr = idx[AW-1:0];
        wr_data = rd_data;
      end
      skt_pkg::WR_NEW: begin
        wr_addr = pos[AW-1:0];
        wr_data = {req_q.part_key, req_q.amount};
      end
      default: begin
        wr_addr = pos[AW-1:0];
        wr_data = {req_q.part_key, sat};
      end
    endcase
  end

  skt_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_sel != skt_pkg::WR_NONE),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    sts.action          = req_q.action;
    sts.full            = (count == IW'(CAPACITY));
    sts.empty           = (count == '0);
    sts.idx_eq_count    = (idx == count);
    sts.idx_eq_pos      = (idx == pos);
    sts.idx_p1_eq_count = (idx_p1 == count);
    sts.key_ge          = (rd_key >= req_q.part_key);
    sts.hit             = hit;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.cap_pos) begin
      pos      <= idx;
      hit      <= (idx != count) && (rd_key == req_q.part_key);
      qty_hold <= rd_qty;
    end
    case (cmd.idx_op)
      skt_pkg::IDX_ZERO:  idx <= '0;
      skt_pkg::IDX_INC:   idx <= idx_p1;
      skt_pkg::IDX_DEC:   idx <= idx_m1;
      skt_pkg::IDX_COUNT: idx <= count;
      skt_pkg::IDX_POS:   idx <= pos;
      default:            idx <= idx;
    endcase
    case (cmd.res_sel)
      skt_pkg::RES_FULL:      res <= {skt_pkg::ST_FULL, req_q.part_key, QW'(0), 1'b1};
      skt_pkg::RES_EXISTS:    res <= {skt_pkg::ST_EXISTS, req_q.part_key, qty_hold, 1'b1};
      skt_pkg::RES_NOT_FOUND: res <= {skt_pkg::ST_NOT_FOUND, req_q.part_key, QW'(0), 1'b1};
      skt_pkg::RES_HIT:       res <= {skt_pkg::ST_OK, req_q.part_key, qty_hold, 1'b1};
      skt_pkg::RES_SUM:       res <= {skt_pkg::ST_OK, req_q.part_key, sat, 1'b1};
      skt_pkg::RES_NEW:       res <= {skt_pkg::ST_OK, req_q.part_key, req_q.amount, 1'b1};
      skt_pkg::RES_EMPTY:     res <= {skt_pkg::ST_EMPTY, skt_pkg::KEY_W'(0), QW'(0), 1'b1};
      skt_pkg::RES_DUMP:      res <= {skt_pkg::ST_OK, rd_key, rd_qty, sts.idx_p1_eq_count};
      default:                res <= res;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (cmd.res_sel != skt_pkg::RES_NONE);
      case (cmd.cnt_op)
        skt_pkg::CNT_INC: count <= count + IW'(1);
        skt_pkg::CNT_DEC: count <= count - IW'(1);
        default:          count <= count;
      endcase
    end
  end

endmodule

// ===== design/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skt_ctrl
// Request sequencer: scan, shift for insert/erase, dump walk, result issue.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  skt_pkg::sts_t sts,
  output logic          busy,
  output skt_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_DECIDE,
    S_INS_CHK, S_INS_WR, S_ERA_CHK, S_ERA_WR, S_DUMP_RD, S_DUMP_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.idx_op  = skt_pkg::IDX_HOLD;
    cmd.rd_sel  = skt_pkg::RD_IDX;
    cmd.wr_sel  = skt_pkg::WR_NONE;
    cmd.cnt_op  = skt_pkg::CNT_HOLD;
    cmd.res_sel = skt_pkg::RES_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          cmd.idx_op   = skt_pkg::IDX_ZERO;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.action)
          skt_pkg::ACT_INSERT: begin
            if (sts.full) begin
              cmd.res_sel = skt_pkg::RES_FULL;
              state_next  = S_IDLE;
            end else begin
              state_next  = S_SCAN_RD;
            end
          end
          skt_pkg::ACT_SEARCH, skt_pkg::ACT_UPDATE, skt_pkg::ACT_ERASE: begin
            state_next = S_SCAN_RD;
          end
          skt_pkg::ACT_DUMP: begin
            if (sts.empty) begin
              cmd.res_sel = skt_pkg::RES_EMPTY;
              state_next  = S_IDLE;
            end else begin
              state_next  = S_DUMP_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN_RD: begin
        if (sts.idx_eq_count) begin
          cmd.cap_pos = 1'b1;
          state_next  = S_DECIDE;
        end else begin
          state_next  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.key_ge) begin
          cmd.cap_pos = 1'b1;
          state_next  = S_DECIDE;
        end else begin
          cmd.idx_op  = skt_pkg::IDX_INC;
          state_next  = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (!sts.hit && sts.action != skt_pkg::ACT_INSERT) begin
          cmd.res_sel = skt_pkg::RES_NOT_FOUND;
        end else begin
          case (sts.action)
            skt_pkg::ACT_INSERT: begin
              if (sts.hit) begin
                cmd.res_sel = skt_pkg::RES_EXISTS;
              end else begin
                cmd.idx_op  = skt_pkg::IDX_COUNT;
                state_next  = S_INS_CHK;
              end
            end
            skt_pkg::ACT_UPDATE: begin
              cmd.wr_sel  = skt_pkg::WR_SUM;
              cmd.res_sel = skt_pkg::RES_SUM;
            end
            skt_pkg::ACT_ERASE: begin
              cmd.idx_op = skt_pkg::IDX_POS;
              state_next = S_ERA_CHK;
            end
            default: cmd.res_sel = skt_pkg::RES_HIT;
          endcase
        end
      end
      S_INS_CHK: begin
        if (sts.idx_eq_pos) begin
          cmd.wr_sel  = skt_pkg::WR_NEW;
          cmd.cnt_op  = skt_pkg::CNT_INC;
          cmd.res_sel = skt_pkg::RES_NEW;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_sel  = skt_pkg::RD_IDX_M1;
          state_next  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_sel = skt_pkg::WR_SHIFT;
        cmd.idx_op = skt_pkg::IDX_DEC;
        state_next = S_INS_CHK;
      end
      S_ERA_CHK: begin
        if (sts.idx_p1_eq_count) begin
          cmd.cnt_op  = skt_pkg::CNT_DEC;
          cmd.res_sel = skt_pkg::RES_HIT;
          state_next  = S_IDLE;
        end else begin
          cmd.rd_sel  = skt_pkg::RD_IDX_P1;
          state_next  = S_ERA_WR;
        end
      end
      S_ERA_WR: begin
        cmd.wr_sel = skt_pkg::WR_SHIFT;
        cmd.idx_op = skt_pkg::IDX_INC;
        state_next = S_ERA_CHK;
      end
      S_DUMP_RD: begin
        state_next = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        cmd.res_sel = skt_pkg::RES_DUMP;
        if (sts.idx_p1_eq_count) begin
          state_next = S_IDLE;
        end else begin
          cmd.idx_op = skt_pkg::IDX_INC;
          state_next = S_DUMP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== design/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table
// Key/quantity table kept in ascending key order: insert, search, update,
// erase and dump requests over a one-write, one-read entry RAM.
// ----------------------------------------------------------------------------
//   channel   dir  handshake           payload
//   request   in   start & !busy       req (action, part_key, amount)
//   result    out  done, one cycle     res (status, found_key, quantity, last)
//
// The key scan reads and then checks each entry examined, as the RAM's read is
// registered; insert and erase shift one moved entry at a time; a dump gives
// one result per entry. A new request is accepted only after busy has fallen.
// Reset empties the table at once. Results cannot be stalled; busy stays
// high until the last result of a request has been issued.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  skt_pkg::req_t req,
  output logic          done,
  output skt_pkg::res_t res
);

  skt_pkg::cmd_t cmd;
  skt_pkg::sts_t sts;

  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  skt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .done (done),
    .res  (res)
  );

  `ASSERT_RST(a_accept_busy, clk, rst, start && !busy |=> busy, "busy not raised on accept")
  `ASSERT_RST(a_done_in_req, clk, rst, done |-> $past(busy), "result outside a request")
  `ASSERT_RST(a_more_busy, clk, rst, done && !res.last |=> busy, "request ended before last")
  `ASSERT_RST(a_more_ok, clk, rst, done && !res.last |-> res.status == skt_pkg::ST_OK,
              "non-final result not ok")
  `ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !busy && !done, "not idle after reset")

endmodule
